// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define PFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also covers the reset period
`define PFC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/pfc_pkg.sv
// ---------------------------------------------------------------------------
// pfc_pkg
// types, constants and the crc byte update for the packet framer
// ---------------------------------------------------------------------------
package pfc_pkg;

  // largest accepted payload length
  localparam int unsigned MAX_PAYLOAD = 255;
  // crc seed and reflected polynomial
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'd49061;
  // default depth of the front-to-back queue (power of two, at least 2)
  localparam int unsigned QUEUE_DEPTH = 4;

  // input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  // output status codes
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_TOO_BIG = 1'b1;

  // kind of work handed from front to back
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // one queued request
  typedef struct packed {
    kind_e      kind;
    logic [7:0] b0;   // command on start, payload byte on data
    logic [7:0] b1;   // length on start
    logic       fin;  // append the crc after the data bytes
  } entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // one byte into the crc, lsb first
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/pfc_front.sv
// ---------------------------------------------------------------------------
// pfc_front
// accepts input requests, tracks packet state and queues work for the back
// ---------------------------------------------------------------------------
module pfc_front import pfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // command, length, data_byte
  input  logic [0:0]  s_axis_tuser,  // action
  input  q_stat_t     q_stat_i,
  output logic        push_o,
  output entry_t      push_entry_o
);

  logic       in_packet_q, in_packet_d;
  logic [7:0] remain_q, remain_d;
  logic       accept;
  logic       action;
  logic [7:0] command, length, data_byte;
  logic [7:0] remain_dec;

  assign action    = s_axis_tuser[0];
  assign command   = s_axis_tdata[7:0];
  assign length    = s_axis_tdata[15:8];
  assign data_byte = s_axis_tdata[23:16];

  assign s_axis_tready = !q_stat_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign remain_dec    = remain_q - 8'd1;

  // classify the request
  always_comb begin
    in_packet_d  = in_packet_q;
    remain_d     = remain_q;
    push_o       = 1'b0;
    push_entry_o = '{kind: KIND_DATA, b0: data_byte, b1: length, fin: 1'b0};
    if (accept) begin
      if (action == ACT_START) begin
        push_o = 1'b1;
        if ({1'b0, length} > 9'(MAX_PAYLOAD)) begin
          in_packet_d       = 1'b0;
          remain_d          = 8'd0;
          push_entry_o.kind = KIND_ERROR;
        end else begin
          in_packet_d       = (length != 8'd0);
          remain_d          = length;
          push_entry_o.kind = KIND_START;
          push_entry_o.b0   = command;
          push_entry_o.fin  = (length == 8'd0);
        end
      end else if (in_packet_q) begin
        push_o           = 1'b1;
        remain_d         = remain_dec;
        push_entry_o.fin = (remain_dec == 8'd0);
        if (remain_dec == 8'd0) begin
          in_packet_d = 1'b0;
        end
      end
    end
  end

  // packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      remain_q    <= 8'd0;
    end else begin
      in_packet_q <= in_packet_d;
      remain_q    <= remain_d;
    end
  end

endmodule

// File: rtl/pfc_queue.sv
// ---------------------------------------------------------------------------
// pfc_queue
// short fifo of requests between the front and the back
// ---------------------------------------------------------------------------
module pfc_queue import pfc_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  entry_t  push_entry_i,
  input  logic    pop_i,
  output entry_t  head_o,
  output q_stat_t q_stat_o
);

  localparam int unsigned PW = $clog2(QDEPTH);

  entry_t        slots_q [QDEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   count_q;

  assign q_stat_o.full  = (count_q == (PW+1)'(QDEPTH));
  assign q_stat_o.empty = (count_q == '0);
  assign head_o         = slots_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PW+1)'(1);
      end
    end
  end

endmodule

// File: rtl/pfc_back.sv
// ---------------------------------------------------------------------------
// pfc_back
// walks each queued request out as frame bytes and keeps the running crc
// ---------------------------------------------------------------------------
module pfc_back import pfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  entry_t     head_i,
  input  q_stat_t    q_stat_i,
  output logic       pop_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // out_byte
  output logic       m_axis_tlast,  // last_byte
  output logic [0:0] m_axis_tuser   // status
);

  logic [7:0]  device_id_q;
  logic [2:0]  step_q;
  logic [15:0] crc_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic        out_stat_q;

  logic        advance;
  logic [2:0]  n_data;
  logic        data_phase;
  logic [2:0]  crc_step;
  logic [7:0]  data_sel;
  logic [15:0] crc_seed;
  logic [15:0] crc_next;
  logic        entry_done;
  logic [7:0]  byte_d;
  logic        last_d;
  logic        stat_d;

  assign cfg_ready_o = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= 8'd0;
    end else if (cfg_valid_i) begin
      device_id_q <= cfg_data_i;
    end
  end

  assign advance = !q_stat_i.empty && (!out_valid_q || m_axis_tready);

  // byte selection for the current step
  always_comb begin
    n_data     = (head_i.kind == KIND_START) ? 3'd3 : 3'd1;
    data_phase = (step_q < n_data);
    crc_step   = step_q - n_data;
    case (step_q)
      3'd0:    data_sel = (head_i.kind == KIND_START) ? device_id_q : head_i.b0;
      3'd1:    data_sel = head_i.b0;
      default: data_sel = head_i.b1;
    endcase
    crc_seed = (head_i.kind == KIND_START && step_q == 3'd0) ? CRC_INIT : crc_q;
    crc_next = crc_feed(crc_seed, data_sel);

    byte_d     = data_sel;
    last_d     = 1'b0;
    stat_d     = STAT_OK;
    entry_done = 1'b0;
    if (head_i.kind == KIND_ERROR) begin
      byte_d     = 8'd0;
      last_d     = 1'b1;
      stat_d     = STAT_TOO_BIG;
      entry_done = 1'b1;
    end else if (data_phase) begin
      entry_done = (step_q == n_data - 3'd1) && !head_i.fin;
    end else if (crc_step == 3'd0) begin
      byte_d = crc_q[15:8];
    end else begin
      byte_d     = crc_q[7:0];
      last_d     = 1'b1;
      entry_done = 1'b1;
    end
  end

  assign pop_o = advance && entry_done;

  // sequencer step and running crc
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 3'd0;
      crc_q  <= CRC_INIT;
    end else if (advance) begin
      if (head_i.kind != KIND_ERROR && data_phase) begin
        crc_q <= crc_next;
      end
      if (entry_done) begin
        step_q <= 3'd0;
      end else begin
        step_q <= step_q + 3'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= byte_d;
      out_last_q <= last_d;
      out_stat_q <= stat_d;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_byte_q;
  assign m_axis_tlast    = out_last_q;
  assign m_axis_tuser[0] = out_stat_q;

endmodule

// File: rtl/packet_framer_crc16_unit.sv
// ---------------------------------------------------------------------------
// packet_framer_crc16_unit
// transmit frame builder: id, command, length, payload, crc16 high byte first
// ---------------------------------------------------------------------------
// The output side sends one byte per cycle unless the queue is empty or
// m_axis_tready is low. Bytes per request: payload one, last payload three
// (byte plus both crc bytes), start three, zero-length start five, oversized
// start one. The back sequencer and its single output register set the byte
// rate; the input side takes one request per cycle while the queue has room,
// so bursts of starts are absorbed by the queue and then throttled by the
// byte rate. Stray payload requests outside a packet are dropped.
module packet_framer_crc16_unit import pfc_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // device_id
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // command, length, data_byte
  input  logic [0:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast,   // last_byte
  output logic [0:0]  m_axis_tuser    // status
);

`include "assert_macros.svh"

  q_stat_t q_stat;
  logic    push, pop;
  entry_t  push_entry, head;
  logic    out_err;

  // front: classify requests
  pfc_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // queue between front and back
  pfc_queue #(.QDEPTH(QDEPTH)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .q_stat_o     (q_stat)
  );

  // back: emit frame bytes
  pfc_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser
  );

  // error result on the output
  assign out_err = m_axis_tvalid && m_axis_tuser[0];

  // checks
  `PFC_ASSERT(a_no_overflow, push |-> !q_stat.full, "push into full queue")
  `PFC_ASSERT(a_no_underflow, pop |-> !q_stat.empty, "pop from empty queue")
  `PFC_ASSERT(a_error_shape, out_err |-> m_axis_tlast && m_axis_tdata == 8'd0, "bad error result")
  `PFC_ASSERT_RST(a_reset_idle, !rst_ni |=> !m_axis_tvalid, "output valid after reset")

endmodule
